FILE: sv/id3_pkg.sv
// ----------------------------------------------------------------------------
// id3_pkg
// Shared types and constants for the ID3v2 frame text extractor.
// ----------------------------------------------------------------------------
package id3_pkg;

    localparam int BYTE_W  = 8;
    localparam int FIELD_W = 3;
    localparam int LIMIT_W = 13;
    localparam int POS_W   = 30;
    localparam int SIZE_W  = 29;
    localparam int ID_W    = 32;
    localparam int PC_W    = 4;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd5000;
    localparam logic [POS_W-1:0]   HEADER_LEN  = 30'd10;
    localparam logic [23:0]        TAG_MAGIC   = 24'h494433;

    localparam int                 NUM_FIELDS = 6;
    localparam logic [FIELD_W-1:0] FIELD_NONE = 3'd7;
    localparam logic [FIELD_W-1:0] FIELD_ZERO = 3'd0;

    // index 0 title, 1 artist, 2 album, 3 year, 4 comment, 5 genre
    localparam logic [NUM_FIELDS-1:0][ID_W-1:0] FRAME_IDS = {
        32'h54434F4E,   // TCON
        32'h434F4D4D,   // COMM
        32'h54594552,   // TYER
        32'h54414C42,   // TALB
        32'h54504531,   // TPE1
        32'h54495432    // TIT2
    };

    typedef enum logic [1:0] {
        EV_TEXT  = 2'd0,
        EV_END   = 2'd1,
        EV_NOTAG = 2'd2
    } t_event;

    typedef struct packed {
        logic              sof;
        logic [BYTE_W-1:0] byte_value;
    } t_item;

    typedef struct packed {
        t_event             event_res;
        logic [FIELD_W-1:0] field;
        logic [BYTE_W-1:0]  text_byte;
        logic               last_in_field;
    } t_result;

endpackage

FILE: sv/id3_in_if.sv
// ----------------------------------------------------------------------------
// id3_in_if
// Byte stream channel: one file byte per beat, first byte flagged.
// ----------------------------------------------------------------------------
interface id3_in_if;
    logic       valid;
    logic       ready;
    logic       start_of_file;
    logic [7:0] byte_value;

    modport source (output valid, output start_of_file, output byte_value, input ready);
    modport sink   (input valid, input start_of_file, input byte_value, output ready);
endinterface

FILE: sv/id3_out_if.sv
// ----------------------------------------------------------------------------
// id3_out_if
// Result channel: one text event per beat.
// ----------------------------------------------------------------------------
interface id3_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_res;
    logic [2:0] field;
    logic [7:0] text_byte;
    logic       last_in_field;

    modport source (
        output valid, output event_res, output field, output text_byte,
        output last_in_field, input ready
    );
    modport sink (
        input valid, input event_res, input field, input text_byte,
        input last_in_field, output ready
    );
endinterface

FILE: sv/id3_cfg_if.sv
// ----------------------------------------------------------------------------
// id3_cfg_if
// Configuration write channel for the frame size limit.
// ----------------------------------------------------------------------------
interface id3_cfg_if;
    logic        valid;
    logic        ready;
    logic [12:0] frame_limit;

    modport source (output valid, output frame_limit, input ready);
    modport sink   (input valid, input frame_limit, output ready);
endinterface

FILE: sv/id3v2_frame_text_extractor_core.sv
// ----------------------------------------------------------------------------
// id3v2_frame_text_extractor_core
// Walks an ID3v2 tag byte by byte and emits title, artist, album, year,
// comment and genre text, plus field-end and no-tag events.
// ----------------------------------------------------------------------------
// A byte beat is registered in id3_in_stage, and its result beat in the parser.
// Throughput: one byte per cycle while the result channel is not stalled.
// Reset: synchronous, active low; frame_limit returns to 5000 and the parser
// idles, ignoring bytes until one flagged start_of_file.
module id3v2_frame_text_extractor_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    id3_in_if.sink    i_in,
    id3_cfg_if.sink   i_cfg,
    id3_out_if.source o_out
);

    logic           in_valid;
    logic           take;
    id3_pkg::t_item in_item;

    id3_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (take),
        .o_valid (in_valid),
        .o_item  (in_item)
    );

    id3_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_valid),
        .i_item  (in_item),
        .o_take  (take),
        .i_cfg   (i_cfg),
        .o_out   (o_out)
    );

endmodule

FILE: sv/id3_in_stage.sv
// ----------------------------------------------------------------------------
// id3_in_stage
// Input register: holds one byte beat until the parser takes it.
// ----------------------------------------------------------------------------
module id3_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    id3_in_if.sink         i_in,
    input  logic           i_take,
    output logic           o_valid,
    output id3_pkg::t_item o_item
);

    logic           r_valid;
    id3_pkg::t_item r_item;

    assign i_in.ready = !r_valid || i_take;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.sof        <= i_in.start_of_file;
            r_item.byte_value <= i_in.byte_value;
        end
    end

endmodule

FILE: sv/id3_parser.sv
// ----------------------------------------------------------------------------
// id3_parser
// Tag and frame walk state, frame limit register and result register.
// ----------------------------------------------------------------------------
module id3_parser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  id3_pkg::t_item i_item,
    output logic           o_take,
    id3_cfg_if.sink        i_cfg,
    id3_out_if.source      o_out
);

    typedef enum logic [2:0] {
        PH_DONE  = 3'd0,
        PH_HEAD  = 3'd1,
        PH_ID    = 3'd2,
        PH_SIZE  = 3'd3,
        PH_FLAGS = 3'd4,
        PH_DATA  = 3'd5,
        PH_SKIP  = 3'd6
    } t_phase;

    t_phase                              r_phase, n_phase, c_phase;
    logic [id3_pkg::PC_W-1:0]            r_pc, n_pc, c_pc;
    logic [id3_pkg::POS_W-1:0]           r_pos, n_pos, c_pos;
    logic [id3_pkg::POS_W-1:0]           r_tag_end, n_tag_end, c_tag_end;
    logic [id3_pkg::SIZE_W-1:0]          r_size, n_size, c_size, head_size;
    logic [id3_pkg::ID_W-1:0]            r_ident, n_ident, c_ident;
    logic [id3_pkg::LIMIT_W-1:0]         r_rem, n_rem, c_rem;
    logic [id3_pkg::FIELD_W-1:0]         r_sel, n_sel, c_sel, match_sel;
    logic                                r_ended, n_ended, c_ended;
    logic [id3_pkg::LIMIT_W-1:0]         r_limit;
    logic                                r_out_valid;
    id3_pkg::t_result                    r_res, n_res;
    logic                                n_emit;
    logic                                fire;
    logic                                data_first;
    logic                                data_last;
    logic [1:0]                          size_idx;
    logic [id3_pkg::BYTE_W-1:0]          b;

    function automatic logic [id3_pkg::SIZE_W-1:0] size_part(
        input logic [id3_pkg::BYTE_W-1:0] val,
        input logic [1:0]                 idx
    );
        logic [id3_pkg::SIZE_W-1:0] wide;
        wide = id3_pkg::SIZE_W'(val);
        unique case (idx)
            2'd0:    size_part = wide << 21;
            2'd1:    size_part = wide << 14;
            2'd2:    size_part = wide << 7;
            default: size_part = wide;
        endcase
    endfunction

    assign fire           = i_valid && (!r_out_valid || o_out.ready);
    assign o_take         = fire;
    assign i_cfg.ready    = 1'b1;
    assign b              = i_item.byte_value;

    assign o_out.valid         = r_out_valid;
    assign o_out.event_res     = r_res.event_res;
    assign o_out.field         = r_res.field;
    assign o_out.text_byte     = r_res.text_byte;
    assign o_out.last_in_field = r_res.last_in_field;

    always_comb begin
        match_sel = id3_pkg::FIELD_NONE;
        for (int i = id3_pkg::NUM_FIELDS - 1; i >= 0; i--) begin
            if (c_ident == id3_pkg::FRAME_IDS[i]) begin
                match_sel = id3_pkg::FIELD_W'(i);
            end
        end
    end

    always_comb begin
        if (i_item.sof) begin
            c_phase   = PH_HEAD;
            c_pc      = '0;
            c_pos     = '0;
            c_tag_end = '0;
            c_size    = '0;
            c_ident   = '0;
            c_rem     = '0;
            c_sel     = id3_pkg::FIELD_NONE;
            c_ended   = 1'b0;
        end else begin
            c_phase   = r_phase;
            c_pc      = r_pc;
            c_pos     = r_pos;
            c_tag_end = r_tag_end;
            c_size    = r_size;
            c_ident   = r_ident;
            c_rem     = r_rem;
            c_sel     = r_sel;
            c_ended   = r_ended;
        end

        n_phase   = c_phase;
        n_pc      = c_pc;
        n_pos     = (c_phase == PH_DONE) ? c_pos : c_pos + 1'b1;
        n_tag_end = c_tag_end;
        n_size    = c_size;
        n_ident   = c_ident;
        n_rem     = c_rem;
        n_sel     = c_sel;
        n_ended   = c_ended;
        n_emit    = 1'b0;
        n_res     = '{event_res: id3_pkg::EV_TEXT, field: id3_pkg::FIELD_ZERO,
                      text_byte: '0, last_in_field: 1'b0};
        head_size  = c_size;
        size_idx   = (c_pc > 4'd3) ? 2'd3 : c_pc[1:0];
        data_first = (c_pc == '0);
        data_last  = ((c_rem - 1'b1) == '0);

        unique case (c_phase)
            PH_DONE: begin
            end
            PH_HEAD: begin
                if (c_pc < 4'd3) begin
                    n_ident = {c_ident[23:0], b};
                end else if (c_pc >= 4'd6 && c_pc <= 4'd9) begin
                    head_size = c_size | size_part(b, 2'(c_pc - 4'd6));
                    n_size    = head_size;
                end
                n_pc = c_pc + 1'b1;
                if (c_pc >= 4'd9) begin
                    if (c_ident[23:0] != id3_pkg::TAG_MAGIC) begin
                        n_phase             = PH_DONE;
                        n_emit              = 1'b1;
                        n_res.event_res     = id3_pkg::EV_NOTAG;
                    end else begin
                        n_tag_end = {1'b0, head_size} + id3_pkg::HEADER_LEN;
                        n_pc      = '0;
                        n_ident   = '0;
                        n_size    = '0;
                        n_phase   = (n_pos < n_tag_end) ? PH_ID : PH_DONE;
                    end
                end
            end
            PH_ID: begin
                if (c_pc == '0 && b == '0) begin
                    n_phase = PH_DONE;
                end else begin
                    n_ident = {c_ident[23:0], b};
                    n_pc    = c_pc + 1'b1;
                    if (c_pc >= 4'd3) begin
                        n_phase = PH_SIZE;
                        n_pc    = '0;
                        n_size  = '0;
                    end
                end
            end
            PH_SIZE: begin
                n_size = c_size | size_part(b, size_idx);
                n_pc   = {2'b00, size_idx} + 1'b1;
                if (size_idx == 2'd3) begin
                    n_phase = PH_FLAGS;
                    n_pc    = '0;
                end
            end
            PH_FLAGS: begin
                n_pc = c_pc + 1'b1;
                if (c_pc >= 4'd1) begin
                    n_pc = '0;
                    if (c_size == '0 ||
                        c_size > id3_pkg::SIZE_W'(r_limit)) begin
                        n_phase = PH_SKIP;
                    end else begin
                        n_phase = PH_DATA;
                        n_rem   = c_size[id3_pkg::LIMIT_W-1:0];
                        n_sel   = match_sel;
                        n_ended = 1'b0;
                    end
                end
            end
            PH_SKIP: begin
                n_pc    = '0;
                n_ident = '0;
                n_size  = '0;
                n_phase = (n_pos < c_tag_end) ? PH_ID : PH_DONE;
            end
            PH_DATA: begin
                n_pc  = 4'd1;
                n_rem = c_rem - 1'b1;
                if (c_sel < 3'd6 && !c_ended) begin
                    n_res.field = c_sel;
                    if (data_first) begin
                        if (data_last) begin
                            n_ended         = 1'b1;
                            n_emit          = 1'b1;
                            n_res.event_res = id3_pkg::EV_END;
                        end
                    end else if (b == '0) begin
                        n_ended         = 1'b1;
                        n_emit          = 1'b1;
                        n_res.event_res = id3_pkg::EV_END;
                    end else begin
                        n_emit              = 1'b1;
                        n_res.event_res     = id3_pkg::EV_TEXT;
                        n_res.text_byte     = b;
                        n_res.last_in_field = data_last;
                    end
                end
                if (data_last) begin
                    n_pc    = '0;
                    n_ident = '0;
                    n_size  = '0;
                    n_phase = (n_pos < c_tag_end) ? PH_ID : PH_DONE;
                end
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_DONE;
            r_pc        <= '0;
            r_pos       <= '0;
            r_tag_end   <= '0;
            r_size      <= '0;
            r_ident     <= '0;
            r_rem       <= '0;
            r_sel       <= id3_pkg::FIELD_NONE;
            r_ended     <= 1'b0;
            r_limit     <= id3_pkg::LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_limit <= i_cfg.frame_limit;
            end
            if (fire) begin
                r_phase     <= n_phase;
                r_pc        <= n_pc;
                r_pos       <= n_pos;
                r_tag_end   <= n_tag_end;
                r_size      <= n_size;
                r_ident     <= n_ident;
                r_rem       <= n_rem;
                r_sel       <= n_sel;
                r_ended     <= n_ended;
                r_out_valid <= n_emit;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && n_emit) begin
            r_res <= n_res;
        end
    end

endmodule

FILE: sv/id3_checker.sv
// ----------------------------------------------------------------------------
// id3_checker
// Port-level checks on the result channel of the extractor core.
// ----------------------------------------------------------------------------
module id3_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_event_res,
    input logic [2:0] i_field,
    input logic [7:0] i_text_byte,
    input logic       i_last_in_field
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result beat valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_event_res) &&
            $stable(i_field) && $stable(i_text_byte) && $stable(i_last_in_field))
        else $error("stalled result beat changed");

    a_notag_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_event_res == id3_pkg::EV_NOTAG |->
            i_field == '0 && i_text_byte == '0 && !i_last_in_field)
        else $error("no-tag beat carries field data");

    a_end_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_event_res == id3_pkg::EV_END |->
            i_text_byte == '0 && !i_last_in_field && i_field != 3'd6 &&
            i_field != 3'd7)
        else $error("field end beat malformed");

    a_text_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_event_res == id3_pkg::EV_TEXT |->
            i_text_byte != '0 && i_field != 3'd6 && i_field != 3'd7)
        else $error("text beat with NUL byte or unknown field");

endmodule

bind id3v2_frame_text_extractor_core id3_checker u_id3_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_event_res     (o_out.event_res),
    .i_field         (o_out.field),
    .i_text_byte     (o_out.text_byte),
    .i_last_in_field (o_out.last_in_field)
);

FILE: dv/tb_id3v2_frame_text_extractor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_id3v2_frame_text_extractor_core
// Self-checking bench for the ID3v2 frame text extractor. Feeds short files
// (tagged, untagged, cut off and stray bytes) under several frame_limit values,
// predicts every text event in a scoreboard and checks each output beat in
// order, with random stalls on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_id3v2_frame_text_extractor_core;
    import id3_pkg::*;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int HOLD_CYCLES   = 600;
    localparam int SETTLE_CYCLES = 6;
    localparam int FLUSH_CYCLES  = 20;
    localparam int PHASE_BYTES   = 12;
    localparam int NUM_PHASES    = 6;
    localparam int BIG_FRAME     = 130;

    typedef enum logic [2:0] {
        PH_IDLE, PH_HEADER, PH_FRAME_ID, PH_FRAME_SIZE, PH_FLAGS, PH_DATA, PH_SKIP
    } t_parse_phase;

    class text_event_tracker;
        logic [LIMIT_W-1:0] frame_limit;
        t_parse_phase       phase;
        logic [PC_W-1:0]    step_cnt;
        logic [POS_W-1:0]   position;
        logic [POS_W-1:0]   tag_end;
        logic [SIZE_W-1:0]  size_acc;
        logic [ID_W-1:0]    ident;
        logic [LIMIT_W-1:0] remaining;
        logic [FIELD_W-1:0] sel_field;
        logic               text_done;
        t_result            pending_events[$];
        int                 errors;
        int                 parsed_bytes;
        int                 checked_events;

        function new();
            frame_limit    = LIMIT_RESET;
            errors         = 0;
            parsed_bytes   = 0;
            checked_events = 0;
            clear_parse();
        endfunction

        function void clear_parse();
            phase     = PH_IDLE;
            step_cnt  = '0;
            position  = '0;
            tag_end   = '0;
            size_acc  = '0;
            ident     = '0;
            remaining = '0;
            sel_field = FIELD_NONE;
            text_done = 1'b0;
        endfunction

        function void next_frame();
            step_cnt = '0;
            ident    = '0;
            size_acc = '0;
            phase    = (position < tag_end) ? PH_FRAME_ID : PH_IDLE;
        endfunction

        function void expect_event(t_event ev, logic [FIELD_W-1:0] fld,
                                   logic [BYTE_W-1:0] ch, logic last);
            t_result r;
            r.event_res     = ev;
            r.field         = fld;
            r.text_byte     = ch;
            r.last_in_field = last;
            pending_events.push_back(r);
        endfunction

        function int pending();
            return pending_events.size();
        endfunction

        function void note_byte(logic sof, logic [BYTE_W-1:0] b);
            int c;
            logic first_b;
            logic last_b;
            if (sof) begin
                clear_parse();
                phase = PH_HEADER;
            end
            if (phase == PH_IDLE) return;
            parsed_bytes++;
            position = position + 1'b1;
            c = int'(step_cnt);
            case (phase)
                PH_HEADER: begin
                    if (c < 3)
                        ident = {ident[23:0], b};
                    else if (c >= 6 && c <= 9)
                        size_acc = size_acc | (SIZE_W'(b) << (7 * (9 - c)));
                    step_cnt = step_cnt + 1'b1;
                    if (c >= 9) begin
                        if (ident[23:0] != TAG_MAGIC) begin
                            phase = PH_IDLE;
                            expect_event(EV_NOTAG, FIELD_ZERO, '0, 1'b0);
                        end else begin
                            tag_end = POS_W'(size_acc) + HEADER_LEN;
                            next_frame();
                        end
                    end
                end
                PH_FRAME_ID: begin
                    if (c == 0 && b == 8'h00) begin
                        phase = PH_IDLE;
                    end else begin
                        ident    = {ident[23:0], b};
                        step_cnt = step_cnt + 1'b1;
                        if (c >= 3) begin
                            phase    = PH_FRAME_SIZE;
                            step_cnt = '0;
                            size_acc = '0;
                        end
                    end
                end
                PH_FRAME_SIZE: begin
                    if (c > 3) c = 3;
                    size_acc = size_acc | (SIZE_W'(b) << (7 * (3 - c)));
                    step_cnt = PC_W'(c + 1);
                    if (c == 3) begin
                        phase    = PH_FLAGS;
                        step_cnt = '0;
                    end
                end
                PH_FLAGS: begin
                    step_cnt = PC_W'(c + 1);
                    if (c >= 1) begin
                        step_cnt = '0;
                        if (size_acc == '0 || size_acc > SIZE_W'(frame_limit)) begin
                            phase = PH_SKIP;
                        end else begin
                            phase     = PH_DATA;
                            remaining = size_acc[LIMIT_W-1:0];
                            sel_field = FIELD_NONE;
                            for (int i = NUM_FIELDS - 1; i >= 0; i--)
                                if (ident == FRAME_IDS[i]) sel_field = FIELD_W'(i);
                            text_done = 1'b0;
                        end
                    end
                end
                PH_SKIP: next_frame();
                PH_DATA: begin
                    first_b   = (step_cnt == '0);
                    step_cnt  = PC_W'(1);
                    remaining = remaining - 1'b1;
                    last_b    = (remaining == '0);
                    if (sel_field != FIELD_NONE && !text_done) begin
                        if (first_b) begin
                            if (last_b) begin
                                text_done = 1'b1;
                                expect_event(EV_END, sel_field, '0, 1'b0);
                            end
                        end else if (b == 8'h00) begin
                            text_done = 1'b1;
                            expect_event(EV_END, sel_field, '0, 1'b0);
                        end else begin
                            expect_event(EV_TEXT, sel_field, b, last_b);
                        end
                    end
                    if (last_b) next_frame();
                end
                default: phase = PH_IDLE;
            endcase
        endfunction

        function void check_event(logic [1:0] ev, logic [FIELD_W-1:0] fld,
                                  logic [BYTE_W-1:0] ch, logic last);
            t_result want;
            if (pending_events.size() == 0) begin
                $error("unexpected result beat: event_res %0d field %0d text_byte 0x%02h",
                       ev, fld, ch);
                errors++;
                return;
            end
            want = pending_events.pop_front();
            checked_events++;
            if (ev !== want.event_res) begin
                $error("event_res mismatch: expected %0d, got %0d", want.event_res, ev);
                errors++;
            end
            if (fld !== want.field) begin
                $error("field mismatch: expected %0d, got %0d", want.field, fld);
                errors++;
            end
            if (ch !== want.text_byte) begin
                $error("text_byte mismatch: expected 0x%02h, got 0x%02h", want.text_byte, ch);
                errors++;
            end
            if (last !== want.last_in_field) begin
                $error("last_in_field mismatch: expected %0d, got %0d",
                       want.last_in_field, last);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   hold_req = 1'b0;
    int   cycle_count;

    logic [7:0] file_bytes[$];
    logic [7:0] frame_bytes[$];
    logic [LIMIT_W-1:0] limits[NUM_PHASES];
    int files_tagged = 0;
    int files_untagged = 0;
    int files_cut = 0;
    int files_stray = 0;
    int phase_start;
    int kind;

    text_event_tracker tracker = new();

    id3_in_if  u_in_if();
    id3_cfg_if u_cfg_if();
    id3_out_if u_out_if();

    id3v2_frame_text_extractor_core u_top (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (u_in_if),
        .i_cfg  (u_cfg_if),
        .o_out  (u_out_if)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $error("timeout after %0d cycles, %0d results outstanding",
               cycle_count, tracker.pending());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (u_cfg_if.valid && u_cfg_if.ready)
                tracker.frame_limit = u_cfg_if.frame_limit;
            if (u_in_if.valid && u_in_if.ready)
                tracker.note_byte(u_in_if.start_of_file, u_in_if.byte_value);
            if (u_out_if.valid && u_out_if.ready)
                tracker.check_event(u_out_if.event_res, u_out_if.field,
                                    u_out_if.text_byte, u_out_if.last_in_field);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // output side: random ready, long bursts, and the requested hold-off
    initial begin
        int n;
        int held;
        u_out_if.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_req) begin
                u_out_if.ready <= 1'b0;
                held = 0;
                while (held < HOLD_CYCLES) begin
                    @(posedge clk);
                    held++;
                end
                hold_req = 1'b0;
            end else begin
                u_out_if.ready <= 1'b1;
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120)
                                                : $urandom_range(1, 6);
                repeat (n) @(posedge clk);
                n = pick_gap();
                if (n > 0) begin
                    u_out_if.ready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
            end
        end
    end

    task automatic offer_byte(input logic sof, input logic [7:0] b);
        u_in_if.valid         <= 1'b1;
        u_in_if.start_of_file <= sof;
        u_in_if.byte_value    <= b;
        do @(posedge clk); while (!u_in_if.ready);
    endtask

    task automatic idle_gap();
        int n;
        n = pick_gap();
        if (n > 0) begin
            u_in_if.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_file(input bit with_sof, input bit no_gaps);
        foreach (file_bytes[i]) begin
            offer_byte(with_sof && i == 0, file_bytes[i]);
            if (!no_gaps) idle_gap();
        end
    endtask

    task automatic drain();
        u_in_if.valid <= 1'b0;
        do @(posedge clk); while (tracker.pending() != 0);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        u_cfg_if.valid       <= 1'b1;
        u_cfg_if.frame_limit <= v;
        do @(posedge clk); while (!u_cfg_if.ready);
        u_cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_frame_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return FRAME_IDS[$urandom_range(0, NUM_FIELDS - 1)];
        if (r < 85) return {8'($urandom_range(1, 255)), 24'($urandom())};
        // near miss: one bit off a wanted ID, first byte left nonzero
        return FRAME_IDS[$urandom_range(0, NUM_FIELDS - 1)] ^ (32'h1 << $urandom_range(0, 23));
    endfunction

    function automatic void push_frame(logic [31:0] id, logic [LIMIT_W-1:0] lim, int forced);
        logic [7:0] sz[4];
        int s;
        int eff;
        int nul_at;
        int r;
        int cap;
        r   = $urandom_range(0, 99);
        cap = (lim < 24) ? int'(lim) : 24;
        s   = 0;
        if (forced > 0) s = forced;
        else if (r < 6) s = 0;
        else if (r < 12) s = int'(lim) + 1;
        else if (r < 24 && lim <= 64) s = int'(lim);
        else if (cap > 0) s = $urandom_range(1, cap);
        sz[0] = 8'((s >> 21) & 'h7F);
        sz[1] = 8'((s >> 14) & 'h7F);
        sz[2] = 8'((s >> 7) & 'h7F);
        sz[3] = 8'(s & 'h7F);
        if (s[7] && $urandom_range(0, 2) == 0) begin
            sz[2] = 8'((s >> 8) << 1);
            sz[3] = 8'(s & 'hFF);
        end
        if (forced == 0 && r >= 18 && r < 24 && lim > 64)
            foreach (sz[k]) sz[k] = 8'($urandom_range(0, 255));
        eff = ((int'(sz[0]) << 21) | (int'(sz[1]) << 14) | (int'(sz[2]) << 7) | int'(sz[3]))
              & 'h1FFF_FFFF;
        frame_bytes.push_back(id[31:24]);
        frame_bytes.push_back(id[23:16]);
        frame_bytes.push_back(id[15:8]);
        frame_bytes.push_back(id[7:0]);
        foreach (sz[k]) frame_bytes.push_back(sz[k]);
        frame_bytes.push_back(8'($urandom_range(0, 255)));
        frame_bytes.push_back(8'($urandom_range(0, 255)));
        if (eff == 0 || eff > int'(lim)) begin
            frame_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
            nul_at = (eff > 1 && $urandom_range(0, 6) == 0) ? $urandom_range(1, eff - 1) : 0;
            frame_bytes.push_back(8'($urandom_range(0, 255)));
            for (int j = 1; j < eff; j++) begin
                if (nul_at != 0 && j == nul_at) frame_bytes.push_back(8'h00);
                else if (nul_at != 0 && j > nul_at)
                    frame_bytes.push_back(8'($urandom_range(0, 255)));
                else frame_bytes.push_back(8'($urandom_range(1, 255)));
            end
        end
    endfunction

    function automatic void make_tag_file(logic [LIMIT_W-1:0] lim, bit big);
        int total;
        int ts;
        int r;
        int pad;
        logic [7:0] sz[4];
        frame_bytes.delete();
        file_bytes.delete();
        if (big) push_frame(FRAME_IDS[$urandom_range(0, NUM_FIELDS - 1)], lim, BIG_FRAME);
        repeat ($urandom_range(1, 4)) push_frame(pick_frame_id(), lim, 0);
        total = frame_bytes.size();
        pad   = $urandom_range(0, 4);
        r     = $urandom_range(0, 99);
        if (r < 65) ts = total + pad;
        else if (r < 82) ts = $urandom_range(1, total);
        else ts = 0;
        sz[0] = 8'((ts >> 21) & 'h7F);
        sz[1] = 8'((ts >> 14) & 'h7F);
        sz[2] = 8'((ts >> 7) & 'h7F);
        sz[3] = 8'(ts & 'h7F);
        // walk bounded only by the zero padding
        if (r >= 92) begin
            foreach (sz[k]) sz[k] = 8'($urandom_range(0, 255));
            if (pad == 0) pad = 1;
        end
        file_bytes = '{8'h49, 8'h44, 8'h33};
        repeat (3) file_bytes.push_back(8'($urandom_range(0, 255)));
        foreach (sz[k]) file_bytes.push_back(sz[k]);
        foreach (frame_bytes[k]) file_bytes.push_back(frame_bytes[k]);
        repeat (pad) file_bytes.push_back(8'h00);
    endfunction

    function automatic void make_untagged_file();
        logic [7:0] b;
        file_bytes.delete();
        if ($urandom_range(0, 1) == 0) begin
            b = 8'($urandom_range(0, 255));
            if (b == 8'h33) b = 8'h34;
            file_bytes = '{8'h49, 8'h44, b};
        end else begin
            repeat (3) file_bytes.push_back(8'($urandom_range(0, 255)));
        end
        repeat (7 + $urandom_range(0, 4)) file_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    initial begin
        rst_n                 <= 1'b0;
        u_in_if.valid         <= 1'b0;
        u_in_if.start_of_file <= 1'b0;
        u_in_if.byte_value    <= 8'h00;
        u_cfg_if.valid        <= 1'b0;
        u_cfg_if.frame_limit  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // stray byte after reset, untagged header of mixed bytes, empty tag
        offer_byte(1'b0, 8'hA5);
        file_bytes = '{8'hFF, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_file(1'b1, 1'b1);
        offer_byte(1'b0, 8'h55);
        file_bytes = '{8'h49, 8'h44, 8'h33, 8'h04, 8'h00, 8'h00,
                       8'h00, 8'h00, 8'h00, 8'h00};
        send_file(1'b1, 1'b0);
        offer_byte(1'b0, 8'h49);

        limits = '{13'd1, 13'd8191, 13'd0, 13'd5000,
                   LIMIT_W'($urandom_range(2, 8190)), 13'd37};
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_limit(limits[p]);
            if (p == 1) begin
                make_tag_file(limits[p], 1'b1);
                send_file(1'b1, 1'b0);
                files_tagged++;
            end
            if (p == 3) hold_req = 1'b1;
            phase_start = tracker.parsed_bytes;
            while (tracker.parsed_bytes - phase_start < PHASE_BYTES) begin
                kind = $urandom_range(0, 99);
                if (kind < 8) begin
                    file_bytes.delete();
                    repeat ($urandom_range(1, 6))
                        file_bytes.push_back(8'($urandom_range(0, 255)));
                    send_file(1'b0, 1'b0);
                    files_stray++;
                end else if (kind < 20) begin
                    make_untagged_file();
                    send_file(1'b1, $urandom_range(0, 4) == 0);
                    files_untagged++;
                end else begin
                    make_tag_file(limits[p], 1'b0);
                    if ($urandom_range(0, 9) == 0) begin
                        // restart lands mid-file
                        repeat ($urandom_range(1, file_bytes.size() - 1)) file_bytes.pop_back();
                        files_cut++;
                    end else begin
                        files_tagged++;
                    end
                    if ($urandom_range(0, 4) == 0)
                        repeat ($urandom_range(1, 3))
                            file_bytes.push_back(8'($urandom_range(0, 255)));
                    send_file(1'b1, $urandom_range(0, 4) == 0);
                end
                if ($urandom_range(0, 9) == 0) drain();
            end
        end

        drain();
        repeat (FLUSH_CYCLES) @(posedge clk);
        $display("Sent %0d tagged, %0d untagged, %0d cut-off and %0d stray-byte files "
                 , files_tagged, files_untagged, files_cut, files_stray);
        $display("over %0d frame_limit settings: %0d bytes parsed, %0d result beats checked",
                 NUM_PHASES, tracker.parsed_bytes, tracker.checked_events);
        if (tracker.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
